/* rtl/great_circle_cost_argmin_assert.svh */
// Assertion macros used by the great-circle cost search RTL.
// Included by gcca_ctrl, which checks its own control sequencing.
`ifndef GREAT_CIRCLE_COST_ARGMIN_ASSERT_SVH
`define GREAT_CIRCLE_COST_ARGMIN_ASSERT_SVH

// clocked check, masked while rst is high
`define GCCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define GCCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gcca_pkg.sv */
// Package for the great-circle cost search: field widths, constants,
// controller command codes, CORDIC arctangent table and small helpers.
// No dependencies.
package gcca_pkg;

  localparam int LAT_W     = 24;
  localparam int LON_W     = 25;
  localparam int TOLL_W    = 16;
  localparam int RATE_W    = 16;
  localparam int IDX_W     = 5;
  localparam int DIST_W    = 23;
  localparam int COST_W    = 24;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE       = 2'd2;

  localparam logic signed [LAT_W-1:0]  ORIGIN_LAT_RST = 24'sd2696781;
  localparam logic signed [LON_W-1:0]  ORIGIN_LON_RST = -25'sd564331;
  localparam logic        [RATE_W-1:0] RATE_RST       = 16'd6554;

  // angle reduction, degrees Q.17
  localparam int ANG_W = 29;
  localparam logic signed [ANG_W-1:0] FULL_TURN    = 29'sd47185920;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 29'sd23592960;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 29'sd11796480;

  // CORDIC datapath, Q30
  localparam int CW_W = 34;
  localparam logic signed [CW_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [CW_W-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [CW_W-1:0] HALF_PI     = 34'sd1686629713;

  localparam logic signed [31:0] DEG_TO_RAD = 32'sd18740330;
  localparam logic signed [31:0] EARTH_DIAM = 32'sd12742;

  localparam logic [DIST_W-1:0] DIST_MAX = 23'd5124000;
  localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFF;

  localparam int SQRT_STEPS = 31;

  // datapath operations
  localparam logic [3:0] OP_IDLE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_ANGLE     = 4'd2;
  localparam logic [3:0] OP_ROT_INIT  = 4'd3;
  localparam logic [3:0] OP_ROT_STEP  = 4'd4;
  localparam logic [3:0] OP_TRIG_SAVE = 4'd5;
  localparam logic [3:0] OP_MUL       = 4'd6;
  localparam logic [3:0] OP_POST      = 4'd7;
  localparam logic [3:0] OP_SQRT_INIT = 4'd8;
  localparam logic [3:0] OP_SQRT_STEP = 4'd9;
  localparam logic [3:0] OP_VEC_INIT  = 4'd10;
  localparam logic [3:0] OP_VEC_STEP  = 4'd11;
  localparam logic [3:0] OP_THETA     = 4'd12;
  localparam logic [3:0] OP_FINISH    = 4'd13;

  // trig run selects
  localparam logic [2:0] TRIG_DLAT  = 3'd0;
  localparam logic [2:0] TRIG_DLON  = 3'd1;
  localparam logic [2:0] TRIG_CLAT1 = 3'd2;
  localparam logic [2:0] TRIG_CLAT2 = 3'd3;

  // multiply selects
  localparam logic [2:0] MUL_SDLAT2 = 3'd0;
  localparam logic [2:0] MUL_SDLON2 = 3'd1;
  localparam logic [2:0] MUL_CPROD  = 3'd2;
  localparam logic [2:0] MUL_HAV    = 3'd3;
  localparam logic [2:0] MUL_THETA  = 3'd4;
  localparam logic [2:0] MUL_COST   = 3'd5;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;
    logic [4:0] k;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
  } sqrt_t;

  function automatic logic signed [CW_W-1:0] atan_q30(input logic [4:0] k);
    logic signed [CW_W-1:0] v;
    case (k)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      5'd24: v = 34'sh00000003F;
      5'd25: v = 34'sh00000001F;
      5'd26: v = 34'sh00000000F;
      5'd27: v = 34'sh000000008;
      5'd28: v = 34'sh000000004;
      5'd29: v = 34'sh000000002;
      5'd30: v = 34'sh000000001;
      default: v = 34'sh000000000;
    endcase
    return v;
  endfunction

  // clamp to [-1, 1] in Q30
  function automatic logic signed [31:0] clamp_unit(input logic signed [CW_W-1:0] v);
    logic signed [CW_W-1:0] c;
    if (v > Q30_ONE) c = Q30_ONE;
    else if (v < -Q30_ONE) c = -Q30_ONE;
    else c = v;
    return c[31:0];
  endfunction

  // one restoring square-root step: two radicand bits in, one root bit out
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] bits);
    logic [34:0] rem_n;
    logic [34:0] trial;
    sqrt_t r;
    rem_n = {s.rem, bits};
    trial = {2'b00, s.root, 2'b01};
    if (rem_n >= trial) begin
      r.rem  = 33'(rem_n - trial);
      r.root = {s.root[29:0], 1'b1};
    end else begin
      r.rem  = rem_n[32:0];
      r.root = {s.root[29:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/gcca_in_if.sv */
// Destination item channel: valid/ready plus coordinates, toll and set end.
// Depends on gcca_pkg.
interface gcca_in_if;
  import gcca_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [LAT_W-1:0]  latitude;
  logic signed [LON_W-1:0]  longitude;
  logic        [TOLL_W-1:0] toll;
  logic                     last_item;

  modport source(output valid, latitude, longitude, toll, last_item, input ready);
  modport sink(input valid, latitude, longitude, toll, last_item, output ready);
endinterface

/* rtl/gcca_out_if.sv */
// Result item channel: valid/ready plus distance, cost and best-so-far report.
// Depends on gcca_pkg.
interface gcca_out_if;
  import gcca_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  item_index;
  logic [DIST_W-1:0] distance_km;
  logic [COST_W-1:0] item_cost;
  logic              best_valid;
  logic [IDX_W-1:0]  best_index;
  logic [COST_W-1:0] best_cost;

  modport source(output valid, item_index, distance_km, item_cost, best_valid, best_index,
                 best_cost, input ready);
  modport sink(input valid, item_index, distance_km, item_cost, best_valid, best_index,
               best_cost, output ready);
endinterface

/* rtl/great_circle_cost_argmin.sv */
// One item is in flight at a time; four sine/cosine runs and one arctangent run share a
// single CORDIC rotator, plus a square-root pass.
// The input is taken again once the result is loaded, even if it is not yet taken.
// Reset (rst, synchronous): config returns to defaults, running best and index clear.
module great_circle_cost_argmin #(
  parameter int MAX_ITEMS    = 32,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  gcca_in_if.sink                        dst_in,
  gcca_out_if.source                     res_out,
  input  logic                           cfg_write,
  input  logic [gcca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcca_pkg::CFG_W-1:0]     cfg_data
);
  import gcca_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gcca_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dst_in.valid),
    .in_ready (dst_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcca_datapath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .latitude    (dst_in.latitude),
    .longitude   (dst_in.longitude),
    .toll        (dst_in.toll),
    .last_item   (dst_in.last_item),
    .out_valid   (res_out.valid),
    .out_ready   (res_out.ready),
    .item_index  (res_out.item_index),
    .distance_km (res_out.distance_km),
    .item_cost   (res_out.item_cost),
    .best_valid  (res_out.best_valid),
    .best_index  (res_out.best_index),
    .best_cost   (res_out.best_cost)
  );

endmodule

/* rtl/gcca_datapath.sv */
// Datapath: config registers, angle reduction, shared multiplier, CORDIC
// rotator/vectorer, dual square-root lanes, argmin state and output register.
// Depends on gcca_pkg; driven by gcca_ctrl commands.
module gcca_datapath #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gcca_pkg::cmd_t                     cmd,
  output gcca_pkg::stat_t                    stat,
  input  logic                               cfg_write,
  input  logic [gcca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcca_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [gcca_pkg::LAT_W-1:0]  latitude,
  input  logic signed [gcca_pkg::LON_W-1:0]  longitude,
  input  logic        [gcca_pkg::TOLL_W-1:0] toll,
  input  logic                               last_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gcca_pkg::IDX_W-1:0]         item_index,
  output logic [gcca_pkg::DIST_W-1:0]        distance_km,
  output logic [gcca_pkg::COST_W-1:0]        item_cost,
  output logic                               best_valid,
  output logic [gcca_pkg::IDX_W-1:0]         best_index,
  output logic [gcca_pkg::COST_W-1:0]        best_cost
);
  import gcca_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ITEMS - 1);

  // config
  logic signed [LAT_W-1:0]  origin_lat;
  logic signed [LON_W-1:0]  origin_lon;
  logic        [RATE_W-1:0] rate;

  // captured item
  logic signed [LAT_W-1:0]  lat_r;
  logic signed [LON_W-1:0]  lon_r;
  logic        [TOLL_W-1:0] toll_r;
  logic                     last_r;

  logic                     fold_neg;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       mul_p;
  logic signed [CW_W-1:0]   x, y, z;
  logic signed [31:0]       s_dlat, s_dlon, c_lat1, c_lat2;
  logic signed [31:0]       hav_a, t_dlon, cprod;
  logic        [30:0]       hav;
  logic        [61:0]       rad_h, rad_c;
  sqrt_t                    sq_h, sq_c;
  logic signed [31:0]       theta;
  logic        [DIST_W-1:0] dist_q8;
  logic        [COST_W-1:0] cost;

  // argmin state
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  run_idx;
  logic [COST_W-1:0] run_cost;

  // angle reduction
  logic signed [ANG_W-1:0] ang_raw, ang_mod, ang_wrap, ang_fold;
  logic                    ang_neg;

  always_comb begin
    case (cmd.sel)
      TRIG_DLAT:  ang_raw = ANG_W'(lat_r) - ANG_W'(origin_lat);
      TRIG_DLON:  ang_raw = ANG_W'(lon_r) - ANG_W'(origin_lon);
      TRIG_CLAT1: ang_raw = ANG_W'(origin_lat) + ANG_W'(origin_lat);
      default:    ang_raw = ANG_W'(lat_r) + ANG_W'(lat_r);
    endcase
    if (ang_raw >= FULL_TURN) ang_mod = ang_raw - FULL_TURN;
    else if (ang_raw >= 0) ang_mod = ang_raw;
    else if (ang_raw + FULL_TURN >= 0) ang_mod = ang_raw + FULL_TURN;
    else ang_mod = ang_raw + FULL_TURN + FULL_TURN;
    if (ang_mod >= HALF_TURN) ang_wrap = ang_mod - FULL_TURN;
    else ang_wrap = ang_mod;
    ang_neg = 1'b0;
    if (ang_wrap > QUARTER_TURN) begin
      ang_fold = HALF_TURN - ang_wrap;
      ang_neg  = 1'b1;
    end else if (ang_wrap < -QUARTER_TURN) begin
      ang_fold = (-HALF_TURN) - ang_wrap;
      ang_neg  = 1'b1;
    end else begin
      ang_fold = ang_wrap;
    end
  end

  // CORDIC step terms
  logic signed [CW_W-1:0] x_sh, y_sh, atan_k;
  logic signed [31:0]     sin_c, cos_c;

  always_comb begin
    x_sh   = x >>> cmd.k;
    y_sh   = y >>> cmd.k;
    atan_k = atan_q30(cmd.k);
    sin_c  = clamp_unit(y);
    cos_c  = fold_neg ? -clamp_unit(x) : clamp_unit(x);
  end

  // product post-processing
  logic signed [63:0] p_shift;
  logic signed [31:0] p_q30;
  logic signed [32:0] hav_sum;
  logic signed [63:0] dist_rnd;
  logic        [63:0] cost_rnd;
  logic        [25:0] cost_sum;
  logic signed [CW_W-1:0] theta_c;

  always_comb begin
    p_shift  = mul_p >>> 30;
    p_q30    = p_shift[31:0];
    hav_sum  = 33'(hav_a) + 33'(p_q30);
    dist_rnd = (mul_p + 64'sd2097152) >>> 22;
    cost_rnd = (64'(mul_p) + 64'd32768) >> 16;
    cost_sum = 26'(cost_rnd[22:0]) + {2'b00, toll_r, 8'h00};
    if (z < 0) theta_c = '0;
    else if (z > HALF_PI) theta_c = HALF_PI;
    else theta_c = z;
  end

  // argmin update
  logic              upd;
  logic [COST_W-1:0] nb_cost;
  logic [CNT_W-1:0]  nb_idx;

  always_comb begin
    upd     = (cnt == '0) || (cost < run_cost);
    nb_cost = upd ? cost : run_cost;
    nb_idx  = upd ? cnt : run_idx;
  end

  assign stat.out_busy = out_valid && !out_ready;

  // control and config state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_lat <= ORIGIN_LAT_RST;
      origin_lon <= ORIGIN_LON_RST;
      rate       <= RATE_RST;
      cnt        <= '0;
      run_idx    <= '0;
      run_cost   <= COST_MAX;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ORIGIN_LAT: origin_lat <= cfg_data[LAT_W-1:0];
          REG_ORIGIN_LON: origin_lon <= cfg_data[LON_W-1:0];
          REG_RATE:       rate       <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_FINISH) begin
        out_valid <= 1'b1;
        if (last_r) begin
          run_cost <= COST_MAX;
          run_idx  <= '0;
          cnt      <= '0;
        end else begin
          run_cost <= nb_cost;
          run_idx  <= nb_idx;
          if (cnt != CNT_LAST) cnt <= cnt + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    unique case (cmd.op)
      OP_LOAD: begin
        lat_r  <= latitude;
        lon_r  <= longitude;
        toll_r <= toll;
        last_r <= last_item;
      end
      OP_ANGLE: begin
        mul_a    <= 32'(ang_fold);
        mul_b    <= DEG_TO_RAD;
        fold_neg <= ang_neg;
      end
      OP_ROT_INIT: begin
        x <= CORDIC_GAIN;
        y <= '0;
        z <= CW_W'(mul_p >>> 17);
      end
      OP_ROT_STEP: begin
        if (z >= 0) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_k;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_k;
        end
      end
      OP_TRIG_SAVE: begin
        case (cmd.sel)
          TRIG_DLAT:  s_dlat <= sin_c;
          TRIG_DLON:  s_dlon <= sin_c;
          TRIG_CLAT1: c_lat1 <= cos_c;
          default:    c_lat2 <= cos_c;
        endcase
      end
      OP_MUL: begin
        case (cmd.sel)
          MUL_SDLAT2: begin mul_a <= s_dlat; mul_b <= s_dlat; end
          MUL_SDLON2: begin mul_a <= s_dlon; mul_b <= s_dlon; end
          MUL_CPROD:  begin mul_a <= c_lat1; mul_b <= c_lat2; end
          MUL_HAV:    begin mul_a <= t_dlon; mul_b <= cprod;  end
          MUL_THETA:  begin mul_a <= theta;  mul_b <= EARTH_DIAM; end
          default:    begin mul_a <= 32'(dist_q8); mul_b <= 32'(rate); end
        endcase
      end
      OP_POST: begin
        case (cmd.sel)
          MUL_SDLAT2: hav_a  <= p_q30;
          MUL_SDLON2: t_dlon <= p_q30;
          MUL_CPROD:  cprod  <= p_q30;
          MUL_HAV: begin
            if (hav_sum < 0) hav <= '0;
            else if (hav_sum > 33'(Q30_ONE)) hav <= 31'(Q30_ONE);
            else hav <= hav_sum[30:0];
          end
          MUL_THETA: begin
            if (dist_rnd > 64'(DIST_MAX)) dist_q8 <= DIST_MAX;
            else dist_q8 <= dist_rnd[DIST_W-1:0];
          end
          default: begin
            if (cost_sum > 26'(COST_MAX)) cost <= COST_MAX;
            else cost <= cost_sum[COST_W-1:0];
          end
        endcase
      end
      OP_SQRT_INIT: begin
        rad_h <= 62'(hav) << 30;
        rad_c <= 62'(31'(Q30_ONE) - hav) << 30;
        sq_h  <= '0;
        sq_c  <= '0;
      end
      OP_SQRT_STEP: begin
        sq_h  <= sqrt_step(sq_h, rad_h[61:60]);
        sq_c  <= sqrt_step(sq_c, rad_c[61:60]);
        rad_h <= rad_h << 2;
        rad_c <= rad_c << 2;
      end
      OP_VEC_INIT: begin
        y <= CW_W'(sq_h.root);
        x <= CW_W'(sq_c.root);
        z <= '0;
      end
      OP_VEC_STEP: begin
        if (y > 0) begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_k;
        end else begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_k;
        end
      end
      OP_THETA: theta <= theta_c[31:0];
      OP_FINISH: begin
        item_index  <= IDX_W'(cnt);
        distance_km <= dist_q8;
        item_cost   <= cost;
        best_valid  <= last_r;
        best_index  <= last_r ? IDX_W'(nb_idx) : '0;
        best_cost   <= last_r ? nb_cost : '0;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/gcca_ctrl.sv */
// Sequencer for the great-circle cost search: steps the datapath through
// four trig runs, the haversine products, square roots, arctangent and cost.
// Depends on gcca_pkg and great_circle_cost_argmin_assert.svh.
`include "great_circle_cost_argmin_assert.svh"

module gcca_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gcca_pkg::stat_t stat,
  output gcca_pkg::cmd_t  cmd
);
  import gcca_pkg::*;

  localparam logic [4:0] LAST_ROT  = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0] LAST_SQRT = 5'(SQRT_STEPS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ANG    = 4'd1;
  localparam logic [3:0] S_AWAIT  = 4'd2;
  localparam logic [3:0] S_RINIT  = 4'd3;
  localparam logic [3:0] S_ROT    = 4'd4;
  localparam logic [3:0] S_TSAVE  = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_MWAIT  = 4'd7;
  localparam logic [3:0] S_POST   = 4'd8;
  localparam logic [3:0] S_SQINIT = 4'd9;
  localparam logic [3:0] S_SQRT   = 4'd10;
  localparam logic [3:0] S_VINIT  = 4'd11;
  localparam logic [3:0] S_VEC    = 4'd12;
  localparam logic [3:0] S_THETA  = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state, state_next;
  logic [4:0] k, k_next;
  logic [2:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    sel_next   = sel;
    cmd.op     = OP_IDLE;
    cmd.sel    = sel;
    cmd.k      = k;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          sel_next   = TRIG_DLAT;
          state_next = S_ANG;
        end
      end
      S_ANG: begin
        cmd.op     = OP_ANGLE;
        state_next = S_AWAIT;
      end
      S_AWAIT: state_next = S_RINIT;
      S_RINIT: begin
        cmd.op     = OP_ROT_INIT;
        k_next     = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT_STEP;
        if (k == LAST_ROT) state_next = S_TSAVE;
        else k_next = k + 5'd1;
      end
      S_TSAVE: begin
        cmd.op = OP_TRIG_SAVE;
        if (sel == TRIG_CLAT2) begin
          sel_next   = MUL_SDLAT2;
          state_next = S_MUL;
        end else begin
          sel_next   = sel + 3'd1;
          state_next = S_ANG;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_MWAIT;
      end
      S_MWAIT: state_next = S_POST;
      S_POST: begin
        cmd.op = OP_POST;
        if (sel == MUL_HAV) begin
          state_next = S_SQINIT;
        end else if (sel == MUL_COST) begin
          state_next = S_DONE;
        end else begin
          sel_next   = sel + 3'd1;
          state_next = S_MUL;
        end
      end
      S_SQINIT: begin
        cmd.op     = OP_SQRT_INIT;
        k_next     = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (k == LAST_SQRT) state_next = S_VINIT;
        else k_next = k + 5'd1;
      end
      S_VINIT: begin
        cmd.op     = OP_VEC_INIT;
        k_next     = '0;
        state_next = S_VEC;
      end
      S_VEC: begin
        cmd.op = OP_VEC_STEP;
        if (k == LAST_ROT) state_next = S_THETA;
        else k_next = k + 5'd1;
      end
      S_THETA: begin
        cmd.op     = OP_THETA;
        sel_next   = MUL_THETA;
        state_next = S_MUL;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `GCCA_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state == S_ANG), "accepted item did not start the trig sequence")
  `GCCA_ASSERT(a_finish_slot_free, (cmd.op == OP_FINISH) |-> !stat.out_busy, "result written over an untaken result")
  `GCCA_ASSERT(a_step_bound, (state == S_ROT || state == S_VEC) |-> (k <= LAST_ROT), "CORDIC step count overran")
  `GCCA_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> (state == S_IDLE), "sequencer not idle after reset")

endmodule
